[hdl/mrg_pkg.sv]
// Shared types, recurrence constants and the modular reduction for the MRG32k3a generator.
`timescale 1ns / 1ps
package mrg_pkg;

	// three words of one history, index 0 is the oldest
	typedef logic [2:0][31:0] mrg_hist_t;

	// constants that set up one recurrence
	typedef struct packed {
		logic [20:0] mul_pos;     // multiplier of the positive tap
		logic [20:0] mul_neg;     // multiplier of the oldest word
		logic [31:0] offset;      // folds the inverted oldest word back to a negation
		logic [14:0] fold;        // 2^32 - modulus
		logic [31:0] modulus;
		logic        pos_newest;  // positive tap is the newest word, else the middle one
	} mrg_coef_t;

	localparam logic [31:0] RESET_WORD = 32'd12345;

	localparam logic [63:0] TWO_32   = 64'h1_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF;

	localparam logic [63:0] MOD_ONE = 64'd4294967087;
	localparam logic [63:0] MOD_TWO = 64'd4294944443;
	localparam logic [63:0] MUL_A1  = 64'd1403580;
	localparam logic [63:0] MUL_A0  = 64'd810728;
	localparam logic [63:0] MUL_B2  = 64'd527612;
	localparam logic [63:0] MUL_B0  = 64'd1370589;

	// mul_neg * ~w == mul_neg * (2^32 - 1) - mul_neg * w, so add the negated first term
	localparam logic [63:0] OFS_ONE  = (MOD_ONE - (MUL_A0 * ALL_ONES) % MOD_ONE) % MOD_ONE;
	localparam logic [63:0] OFS_TWO  = (MOD_TWO - (MUL_B0 * ALL_ONES) % MOD_TWO) % MOD_TWO;
	localparam logic [63:0] FOLD_ONE = TWO_32 - MOD_ONE;
	localparam logic [63:0] FOLD_TWO = TWO_32 - MOD_TWO;

	localparam mrg_coef_t COEF_ONE = '{
		mul_pos:    MUL_A1[20:0],
		mul_neg:    MUL_A0[20:0],
		offset:     OFS_ONE[31:0],
		fold:       FOLD_ONE[14:0],
		modulus:    MOD_ONE[31:0],
		pos_newest: 1'b0
	};

	localparam mrg_coef_t COEF_TWO = '{
		mul_pos:    MUL_B2[20:0],
		mul_neg:    MUL_B0[20:0],
		offset:     OFS_TWO[31:0],
		fold:       FOLD_TWO[14:0],
		modulus:    MOD_TWO[31:0],
		pos_newest: 1'b1
	};

	// reduce a sum below 2^54 into [0, modulus), modulus = 2^32 - fold
	function automatic logic [31:0] mod_reduce(input logic [53:0] s,
			input logic [14:0] fold, input logic [31:0] modulus);
		logic [37:0] f1;
		logic [32:0] f2;
		f1 = 38'(s[31:0]) + 38'(s[53:32]) * 38'(fold);
		f2 = 33'(f1[31:0]) + 33'(f1[37:32]) * 33'(fold);
		if (f2 >= 33'(modulus)) begin
			mod_reduce = f2[31:0] - modulus;
		end else begin
			mod_reduce = f2[31:0];
		end
	endfunction

endpackage

[hdl/mrg_recur.sv]
// One order-3 recurrence: three-word history and its combinational update, registered on each step.
`timescale 1ns / 1ps
module mrg_recur (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              reload,
	input  mrg_pkg::mrg_hist_t seed,
	input  mrg_pkg::mrg_coef_t coef,
	output logic [31:0]       word
);
	import mrg_pkg::*;

	mrg_hist_t   hist_q;
	mrg_hist_t   cur;
	logic [31:0] pos_w;
	logic [31:0] neg_w;
	logic [53:0] sum;

	// pick the history this step works from
	assign cur   = reload ? seed : hist_q;
	assign pos_w = coef.pos_newest ? cur[2] : cur[1];
	assign neg_w = ~cur[0];

	// positive tap minus oldest tap, kept non-negative through the offset
	assign sum = 54'(coef.mul_pos) * 54'(pos_w) + 54'(coef.mul_neg) * 54'(neg_w)
		+ 54'(coef.offset);

	assign word = mod_reduce(sum, coef.fold, coef.modulus);

	// shift the history and enter the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= {3{RESET_WORD}};
		end else if (step) begin
			hist_q <= {word, cur[2], cur[1]};
		end
	end

endmodule

[hdl/mrg_outq.sv]
// Result stage: combine both recurrence words and queue samples for the output channel.
`timescale 1ns / 1ps
module mrg_outq #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [31:0] p1,
	input  logic [31:0] p2,
	output logic        full,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sample
);
	import mrg_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [31:0]   p1_s1;
	logic [31:0]   p2_s1;
	logic          vld_s1;
	logic [31:0]   combined;
	logic [31:0]   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [CW:0]   pending;

	// register the step's words for the combine stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			p1_s1 <= p1;
			p2_s1 <= p2;
		end
	end

	// equal words give the full first modulus
	assign combined = (p1_s1 > p2_s1) ? (p1_s1 - p2_s1)
		: (p1_s1 - p2_s1 + MOD_ONE[31:0]);

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign sample    = mem_q[rd_ptr_q];

	// stall intake once queued plus in-flight samples fill the queue
	assign pending = (CW + 1)'(count_q) + (CW + 1)'(vld_s1);
	assign full    = (pending >= (CW + 1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem_q[wr_ptr_q] <= combined;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (vld_s1) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (vld_s1 && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !vld_s1) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/mrg32k3a_generator.sv]
// Top level of the MRG32k3a generator: seed registers, both recurrences, output queue.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------
//  in       | input     | in_valid / in_stall  | reload, emit
//  out      | output    | out_valid / out_stall| sample
//  config   | input     | APB psel/penable     | seed_a0..seed_b2 at 0x00..0x14
//
// One item is taken per cycle while in_stall is low; each recurrence updates its
// history in the cycle of the transfer through one constant multiply-add and a
// two-fold reduction. A sample's words are registered, then combined into the
// output queue. in_stall rises only when the OUT_DEPTH-entry output queue plus
// the sample in flight are full; with OUT_DEPTH of 3 or more an unstalled output
// sustains one item per cycle. Reset sets all seeds and history words to 12345.
`timescale 1ns / 1ps
module mrg32k3a_generator #(
	parameter int OUT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        reload,
	input  logic        emit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sample,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mrg_pkg::*;

	typedef enum logic [2:0] {
		REG_SEED_A0 = 3'd0,
		REG_SEED_A1 = 3'd1,
		REG_SEED_A2 = 3'd2,
		REG_SEED_B0 = 3'd3,
		REG_SEED_B1 = 3'd4,
		REG_SEED_B2 = 3'd5
	} reg_idx_t;

	mrg_hist_t   seed_a_q;
	mrg_hist_t   seed_b_q;
	logic        accept;
	logic        wr_en;
	logic [2:0]  reg_idx;
	logic [31:0] p1;
	logic [31:0] p2;

	assign accept  = in_valid && !in_stall;
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// write the seed registers, ignore addresses past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= {3{RESET_WORD}};
			seed_b_q <= {3{RESET_WORD}};
		end else if (wr_en) begin
			case (reg_idx)
				REG_SEED_A0: seed_a_q[0] <= pwdata;
				REG_SEED_A1: seed_a_q[1] <= pwdata;
				REG_SEED_A2: seed_a_q[2] <= pwdata;
				REG_SEED_B0: seed_b_q[0] <= pwdata;
				REG_SEED_B1: seed_b_q[1] <= pwdata;
				REG_SEED_B2: seed_b_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	// read back the seed registers
	always_comb begin
		case (reg_idx)
			REG_SEED_A0: prdata = seed_a_q[0];
			REG_SEED_A1: prdata = seed_a_q[1];
			REG_SEED_A2: prdata = seed_a_q[2];
			REG_SEED_B0: prdata = seed_b_q[0];
			REG_SEED_B1: prdata = seed_b_q[1];
			REG_SEED_B2: prdata = seed_b_q[2];
			default:     prdata = '0;
		endcase
	end

	mrg_recur u_recur_one (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.reload (reload),
		.seed   (seed_a_q),
		.coef   (COEF_ONE),
		.word   (p1)
	);

	mrg_recur u_recur_two (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.reload (reload),
		.seed   (seed_b_q),
		.coef   (COEF_TWO),
		.word   (p2)
	);

	mrg_outq #(
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.p1        (p1),
		.p2        (p2),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

endmodule

[tb/testbench.sv]
// Self-checking testbench for the MRG32k3a generator: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module testbench;

	localparam logic [63:0] MOD_ONE = 64'd4294967087;
	localparam logic [63:0] MOD_TWO = 64'd4294944443;
	localparam logic [63:0] MUL_A1  = 64'd1403580;
	localparam logic [63:0] MUL_A0  = 64'd810728;
	localparam logic [63:0] MUL_B2  = 64'd527612;
	localparam logic [63:0] MUL_B0  = 64'd1370589;

	localparam logic [31:0] M1_WORD    = 32'd4294967087;
	localparam logic [31:0] M2_WORD    = 32'd4294944443;
	localparam logic [31:0] INIT_WORD  = 32'd12345;
	// first sample out of the default seeds
	localparam logic [31:0] FIRST_WORD = 32'd545508589;

	localparam int REG_SLOTS     = 8;     // word slots that paddr can address
	localparam int IDLE_LIMIT    = 1000;  // cycles without any transfer
	localparam int PHASE_ITEMS   = 200;
	localparam int PHASE_COUNT   = 6;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		REG_SEED_A0 = 0,
		REG_SEED_A1 = 1,
		REG_SEED_A2 = 2,
		REG_SEED_B0 = 3,
		REG_SEED_B1 = 4,
		REG_SEED_B2 = 5,
		REG_COUNT   = 6
	} seed_reg_t;

	typedef struct {
		int          seed_set;   // -1 keeps the current seeds
		bit          reload;
		bit          emit;
		bit          typed;      // value below is the known sample
		logic [31:0] value;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        reload;
	logic        emit;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] sample;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// generator shadow: seed registers and both histories
	logic [31:0] seed_regs [6];
	logic [31:0] hist_words [6];

	logic [31:0] pending_samples [$];
	logic [31:0] head_sample;
	int          mismatches;
	int          idle_cycles;
	int          send_gap_pct;
	int          stall_pct;

	logic [31:0] dir_seeds [4][6] = '{
		'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{M1_WORD, M1_WORD - 32'd1, M1_WORD, M2_WORD, M2_WORD - 32'd1, M2_WORD},
		'{INIT_WORD, INIT_WORD, INIT_WORD, INIT_WORD, INIT_WORD, INIT_WORD}
	};

	dir_row_t dir_rows [21] = '{
		'{-1, 1'b0, 1'b1, 1'b1, FIRST_WORD},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b0, 1'b0, 32'd0},
		'{-1, 1'b1, 1'b1, 1'b1, FIRST_WORD},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0},
		// zero histories: both recurrences give zero, sample is the modulus
		'{ 0, 1'b1, 1'b1, 1'b1, M1_WORD},
		'{-1, 1'b0, 1'b1, 1'b1, M1_WORD},
		'{-1, 1'b0, 1'b0, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b1, 1'b1, M1_WORD},
		// seeds above both moduli
		'{ 1, 1'b1, 1'b1, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b0, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0},
		'{-1, 1'b1, 1'b0, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0},
		// seeds at and just below the moduli
		'{ 2, 1'b1, 1'b1, 1'b0, 32'd0},
		'{-1, 1'b1, 1'b1, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ 3, 1'b1, 1'b1, 1'b1, FIRST_WORD},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0},
		'{-1, 1'b1, 1'b0, 1'b0, 32'd0},
		'{-1, 1'b0, 1'b1, 1'b0, 32'd0}
	};

	mrg32k3a_generator dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// (pos_mul * x - neg_mul * y) mod m, exact for 32-bit words
	function automatic logic [63:0] lin_mod(input logic [63:0] pos_mul, input logic [63:0] x,
			input logic [63:0] neg_mul, input logic [63:0] y, input logic [63:0] m);
		logic [63:0] pos;
		logic [63:0] neg;
		pos = (pos_mul * x) % m;
		neg = (neg_mul * y) % m;
		return (pos + m - neg) % m;
	endfunction

	// advance both recurrences once and return the combined value
	function automatic logic [31:0] mrg_advance(input bit do_reload);
		logic [63:0] p1;
		logic [63:0] p2;
		logic [63:0] comb;
		if (do_reload) begin
			hist_words = seed_regs;
		end
		p1 = lin_mod(MUL_A1, 64'(hist_words[1]), MUL_A0, 64'(hist_words[0]), MOD_ONE);
		hist_words[0] = hist_words[1];
		hist_words[1] = hist_words[2];
		hist_words[2] = p1[31:0];
		p2 = lin_mod(MUL_B2, 64'(hist_words[5]), MUL_B0, 64'(hist_words[3]), MOD_TWO);
		hist_words[3] = hist_words[4];
		hist_words[4] = hist_words[5];
		hist_words[5] = p2[31:0];
		comb = (p1 <= p2) ? p1 + MOD_ONE - p2 : p1 - p2;
		return comb[31:0];
	endfunction

	// favor zero, all ones and the values around the modulus
	function automatic logic [31:0] pick_seed(input logic [31:0] m);
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return m - 32'd1;
			3: return m;
			4: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t ns %s: want %0d got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// one APB write; psel stays high for a following write
	task automatic write_seed_reg(input int idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx < REG_COUNT) begin
			seed_regs[idx] = value;
		end
	endtask

	// write all six seeds, then hit the unused slots, which must change nothing
	task automatic load_seeds(input logic [31:0] words [6]);
		for (int i = REG_SEED_A0; i < REG_COUNT; i++) begin
			write_seed_reg(i, words[i]);
		end
		for (int i = REG_COUNT; i < REG_SLOTS; i++) begin
			write_seed_reg(i, $urandom);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// hold the input until every sample has come out and the pipe has settled
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// present one step, wait for its transfer, then predict
	task automatic issue_step(input bit do_reload, input bit do_emit, input bit typed,
			input logic [31:0] typed_word);
		logic [31:0] predicted;
		if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		reload   <= do_reload;
		emit     <= do_emit;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = mrg_advance(do_reload);
		if (do_emit) begin
			pending_samples.push_back(typed ? typed_word : predicted);
		end
	endtask

	// receiver: stall in bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// check each output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch("sample with nothing pending", 32'd0, sample);
			end else begin
				head_sample = pending_samples.pop_front();
				if (sample !== head_sample) begin
					report_mismatch("sample", head_sample, sample);
				end
			end
		end
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns watchdog: no transfer for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [31:0] fresh [6];
		bit          do_reload;
		bit          do_emit;
		mismatches   = 0;
		idle_cycles  = 0;
		send_gap_pct = 15;
		stall_pct    = 15;
		for (int i = 0; i < 6; i++) begin
			seed_regs[i]  = INIT_WORD;
			hist_words[i] = INIT_WORD;
		end
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		reload   <= 1'b0;
		emit     <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			if (dir_rows[r].seed_set >= 0) begin
				wait_drained();
				load_seeds(dir_seeds[dir_rows[r].seed_set]);
			end
			issue_step(dir_rows[r].reload, dir_rows[r].emit, dir_rows[r].typed,
				dir_rows[r].value);
		end

		// random phases, each with fresh seeds and an idling mix set per phase
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin send_gap_pct = 20; stall_pct = 20; end
				1: begin send_gap_pct = 40; stall_pct = 10; end
				2: begin send_gap_pct = 0;  stall_pct = 0;  end
				3: begin send_gap_pct = 10; stall_pct = 40; end
				4: begin send_gap_pct = 25; stall_pct = 25; end
				default: begin send_gap_pct = 0; stall_pct = 0; end
			endcase
			wait_drained();
			for (int i = REG_SEED_A0; i < REG_COUNT; i++) begin
				fresh[i] = pick_seed(i < REG_SEED_B0 ? M1_WORD : M2_WORD);
			end
			load_seeds(fresh);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// in phase 1, hold off once mid-phase until the output side is empty
				if (ph == 1 && k == PHASE_ITEMS / 2) begin
					wait_drained();
				end
				do_reload = (k == 0) || ($urandom_range(0, 31) == 0);
				do_emit   = ($urandom_range(0, 3) != 0);
				issue_step(do_reload, do_emit, 1'b0, 32'd0);
			end
		end

		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
